>>> hw/rtl/two_level_page_table_engine_core_macros.svh
// Assertion macros for the two-level page table engine core
`ifndef TWO_LEVEL_PAGE_TABLE_ENGINE_CORE_MACROS_SVH
`define TWO_LEVEL_PAGE_TABLE_ENGINE_CORE_MACROS_SVH

// check that cond holds in the cycle in which trig holds
`define TLPT_ASSERT_SAME(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("tlpt assertion failed");

// check that cond holds in the cycle after trig holds
`define TLPT_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("tlpt assertion failed");

`endif

>>> hw/rtl/tlpt_pkg.sv
// Types, constants and helpers shared by the page table engine files
package tlpt_pkg;

   localparam int NUM_TABLES = 64;
   localparam int DIR_ENTRIES = 1024;
   localparam int ENTRIES_PER_TABLE = 1024;

   localparam int DIR_AW = $clog2(DIR_ENTRIES);
   localparam int TI_W = $clog2(ENTRIES_PER_TABLE);
   localparam int TIDX_W = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
   localparam int CNT_W = $clog2(NUM_TABLES + 1);
   localparam int PTE_DEPTH = NUM_TABLES * ENTRIES_PER_TABLE;
   localparam int PTE_AW = TIDX_W + TI_W;

   localparam int LIMIT_W = 7;
   localparam int USED_W = 7;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

   localparam logic [1:0] MODE_MAP = 2'd0;
   localparam logic [1:0] MODE_UNMAP = 2'd1;
   localparam logic [1:0] MODE_XLATE = 2'd2;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_ALREADY = 2'd1;
   localparam logic [1:0] STATUS_EXHAUSTED = 2'd2;

   localparam logic [31:0] FRAME_MASK = ~32'hFFF;
   localparam logic [31:0] OFFSET_MASK = 32'hFFF;
   localparam logic [31:0] PRESENT_BIT = 32'h1;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] virt_addr;
      logic [31:0] phys_addr;
      logic [11:0] page_flags;
   } req_type;

   typedef struct packed {
      logic [31:0]       result_addr;
      logic              mapped;
      logic [1:0]        status;
      logic [USED_W-1:0] tables_used;
   } rsp_type;

   typedef struct packed {
      logic              present;
      logic [TIDX_W-1:0] tidx;
   } dir_ent_type;

   typedef struct packed {
      logic              en;
      logic [DIR_AW-1:0] addr;
      dir_ent_type       data;
   } dir_wr_type;

   typedef struct packed {
      logic              en;
      logic [PTE_AW-1:0] addr;
      logic [31:0]       data;
   } pte_wr_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIR,
      ST_PTE
   } state_type;

   function automatic logic [USED_W-1:0] to_used(input logic [CNT_W-1:0] cnt);
      logic [31:0] wide;
      wide = 32'(cnt);
      return wide[USED_W-1:0];
   endfunction

endpackage

>>> hw/rtl/tlpt_store.sv
// Directory and page-table-entry memories with the post-reset clearing sweep
module tlpt_store (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [tlpt_pkg::DIR_AW-1:0] dir_rd_addr,
   output tlpt_pkg::dir_ent_type       dir_rd_data,
   input  tlpt_pkg::dir_wr_type        dir_wr,
   input  logic [tlpt_pkg::PTE_AW-1:0] pte_rd_addr,
   output logic [31:0]                 pte_rd_data,
   input  tlpt_pkg::pte_wr_type        pte_wr,
   output logic                        clear_done
);

   tlpt_pkg::dir_ent_type dir_mem [tlpt_pkg::DIR_ENTRIES];
   logic [31:0]           pte_mem [tlpt_pkg::PTE_DEPTH];

   tlpt_pkg::dir_ent_type       dir_rd_ff;
   logic [31:0]                 pte_rd_ff;
   logic [tlpt_pkg::PTE_AW-1:0] clr_ff, clr_in;
   logic                        done_ff, done_in;

   tlpt_pkg::dir_wr_type dir_w;
   tlpt_pkg::pte_wr_type pte_w;

   always_comb begin
      clr_in = clr_ff;
      done_in = done_ff;
      if (!done_ff) begin
         if (clr_ff == tlpt_pkg::PTE_AW'(tlpt_pkg::PTE_DEPTH - 1)) begin
            done_in = 1'b1;
         end else begin
            clr_in = clr_ff + 1'b1;
         end
      end
   end

   always_comb begin
      if (!done_ff) begin
         dir_w.en = 1'b1;
         dir_w.addr = clr_ff[tlpt_pkg::DIR_AW-1:0];
         dir_w.data = '0;
         pte_w.en = 1'b1;
         pte_w.addr = clr_ff;
         pte_w.data = '0;
      end else begin
         dir_w = dir_wr;
         pte_w = pte_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         clr_ff <= clr_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dir_w.en) begin
         dir_mem[dir_w.addr] <= dir_w.data;
      end
      dir_rd_ff <= dir_mem[dir_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (pte_w.en) begin
         pte_mem[pte_w.addr] <= pte_w.data;
      end
      pte_rd_ff <= pte_mem[pte_rd_addr];
   end

   assign dir_rd_data = dir_rd_ff;
   assign pte_rd_data = pte_rd_ff;
   assign clear_done = done_ff;

endmodule

>>> hw/rtl/two_level_page_table_engine_core.sv
// Top level of the two-level page table engine: request sequencer and result register
// Sequence: the directory read is issued on accept, the dependent table-entry read in ST_DIR,
// and the result strobe is registered from ST_PTE, where any write-back also happens.
// A new request is taken only in ST_IDLE, once the previous one has left ST_PTE.
// Reset: busy stays high during a clearing sweep over all NUM_TABLES*1024 entries (65536 here).
// Results are strobed for one cycle; the receiver cannot stall.
`include "two_level_page_table_engine_core_macros.svh"

module two_level_page_table_engine_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  tlpt_pkg::req_type             req_data,
   output logic                          rsp_valid,
   output tlpt_pkg::rsp_type             rsp_data,
   input  logic                          csr_we,
   input  logic [tlpt_pkg::LIMIT_W-1:0]  csr_wdata
);

   tlpt_pkg::state_type state_ff, state_in;
   tlpt_pkg::req_type     req_ff, req_in;
   tlpt_pkg::dir_ent_type dir_ent_ff, dir_ent_in;
   tlpt_pkg::rsp_type     rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [tlpt_pkg::CNT_W-1:0]   alloc_ff, alloc_in;
   logic [tlpt_pkg::LIMIT_W-1:0] limit_ff, limit_in;

   tlpt_pkg::dir_ent_type       dir_rd_data;
   logic [31:0]                 pte_rd_data;
   logic [tlpt_pkg::DIR_AW-1:0] dir_rd_addr;
   logic [tlpt_pkg::PTE_AW-1:0] pte_rd_addr;
   tlpt_pkg::dir_wr_type        dir_wr;
   tlpt_pkg::pte_wr_type        pte_wr;
   logic                        clear_done;

   logic                        accept;
   logic                        present;
   logic                        pool_full;
   logic [tlpt_pkg::TI_W-1:0]   ti;
   logic [tlpt_pkg::TIDX_W-1:0] new_tidx;

   tlpt_store u_store (
      .clock       (clock),
      .reset       (reset),
      .dir_rd_addr (dir_rd_addr),
      .dir_rd_data (dir_rd_data),
      .dir_wr      (dir_wr),
      .pte_rd_addr (pte_rd_addr),
      .pte_rd_data (pte_rd_data),
      .pte_wr      (pte_wr),
      .clear_done  (clear_done)
   );

   assign busy = (state_ff != tlpt_pkg::ST_IDLE);
   assign accept = start && !busy;
   assign ti = req_ff.virt_addr[12 +: tlpt_pkg::TI_W];
   assign new_tidx = tlpt_pkg::TIDX_W'(alloc_ff);
   assign present = dir_ent_ff.present && pte_rd_data[0];
   assign pool_full = (32'(alloc_ff) >= 32'(limit_ff)) ||
                      (32'(alloc_ff) >= 32'(tlpt_pkg::NUM_TABLES));

   assign dir_rd_addr = req_data.virt_addr[31 -: tlpt_pkg::DIR_AW];
   assign pte_rd_addr = {dir_rd_data.tidx, ti};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tlpt_pkg::ST_CLEAR: if (clear_done) state_in = tlpt_pkg::ST_IDLE;
         tlpt_pkg::ST_IDLE:  if (start) state_in = tlpt_pkg::ST_DIR;
         tlpt_pkg::ST_DIR:   state_in = tlpt_pkg::ST_PTE;
         tlpt_pkg::ST_PTE:   state_in = tlpt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_in = req_ff;
      dir_ent_in = dir_ent_ff;
      alloc_in = alloc_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = 1'b0;
      dir_wr = '0;
      pte_wr = '0;
      limit_in = csr_we ? csr_wdata : limit_ff;
      unique case (state_ff)
         tlpt_pkg::ST_CLEAR: begin
         end
         tlpt_pkg::ST_IDLE: begin
            if (accept) req_in = req_data;
         end
         tlpt_pkg::ST_DIR: begin
            dir_ent_in = dir_rd_data;
         end
         tlpt_pkg::ST_PTE: begin
            rsp_valid_in = 1'b1;
            rsp_in.result_addr = '0;
            rsp_in.mapped = 1'b0;
            rsp_in.status = tlpt_pkg::STATUS_OK;
            unique case (req_ff.mode)
               tlpt_pkg::MODE_MAP: begin
                  if (present) begin
                     rsp_in.mapped = 1'b1;
                     rsp_in.status = tlpt_pkg::STATUS_ALREADY;
                  end else if (!dir_ent_ff.present && pool_full) begin
                     rsp_in.status = tlpt_pkg::STATUS_EXHAUSTED;
                  end else begin
                     pte_wr.en = 1'b1;
                     pte_wr.data = (req_ff.phys_addr & tlpt_pkg::FRAME_MASK) |
                                   32'(req_ff.page_flags) | tlpt_pkg::PRESENT_BIT;
                     if (dir_ent_ff.present) begin
                        pte_wr.addr = {dir_ent_ff.tidx, ti};
                     end else begin
                        pte_wr.addr = {new_tidx, ti};
                        dir_wr.en = 1'b1;
                        dir_wr.addr = req_ff.virt_addr[31 -: tlpt_pkg::DIR_AW];
                        dir_wr.data.present = 1'b1;
                        dir_wr.data.tidx = new_tidx;
                        alloc_in = alloc_ff + 1'b1;
                     end
                  end
               end
               tlpt_pkg::MODE_UNMAP: begin
                  if (present) begin
                     rsp_in.mapped = 1'b1;
                     rsp_in.result_addr = pte_rd_data & tlpt_pkg::FRAME_MASK;
                     pte_wr.en = 1'b1;
                     pte_wr.addr = {dir_ent_ff.tidx, ti};
                     pte_wr.data = '0;
                  end
               end
               tlpt_pkg::MODE_XLATE: begin
                  if (present) begin
                     rsp_in.mapped = 1'b1;
                     rsp_in.result_addr = (pte_rd_data & tlpt_pkg::FRAME_MASK) |
                                          (req_ff.virt_addr & tlpt_pkg::OFFSET_MASK);
                  end
               end
               default: begin
               end
            endcase
            rsp_in.tables_used = tlpt_pkg::to_used(alloc_in);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tlpt_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         alloc_ff <= '0;
         limit_ff <= tlpt_pkg::LIMIT_RESET;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         alloc_ff <= alloc_in;
         limit_ff <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      dir_ent_ff <= dir_ent_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   `TLPT_ASSERT_NEXT(a_strobe_one_cycle, clock, reset, rsp_valid_ff, !rsp_valid_ff)
   `TLPT_ASSERT_NEXT(a_pte_gives_result, clock, reset, state_ff == tlpt_pkg::ST_PTE, rsp_valid_ff)
   `TLPT_ASSERT_SAME(a_alloc_bounded, clock, reset, 1'b1,
                     32'(alloc_ff) <= 32'(tlpt_pkg::NUM_TABLES))
   `TLPT_ASSERT_SAME(a_no_write_while_clearing, clock, reset, !clear_done,
                     !dir_wr.en && !pte_wr.en)

endmodule
